### rtl/core/u8u16_pkg.sv
// shared types and constants of the utf-8 to utf-16 transcoder
package u8u16_pkg;

  // depth of the queue between decoder and unit sequencer
  localparam int unsigned QUEUE_DEPTH = 4;

  // code units
  localparam logic [15:0] QMARK        = 16'h003F;
  localparam logic [15:0] SURR_HI_BASE = 16'hD800;
  localparam logic [15:0] SURR_LO_BASE = 16'hDC00;
  localparam logic [20:0] PLANE1_BASE  = 21'h10000;

  // what follows the question marks of one request
  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_UNIT,
    TAIL_PAIR
  } tail_t;

  // one decoded request: n_qmark question marks, then the tail
  typedef struct packed {
    logic [1:0]  n_qmark;
    tail_t       tail;
    logic [20:0] cp;
    logic        end_flag;
  } desc_t;

endpackage

### rtl/core/u8u16_ifs.sv
// byte and code unit channel interfaces
interface u8u16_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface u8u16_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        run_last;
  logic        string_last;

  modport source (output valid, output code_unit, output run_last, output string_last,
                  input ready);
  modport sink (input valid, input code_unit, input run_last, input string_last,
                output ready);
endinterface

### rtl/core/u8u16_front.sv
// byte classifier and sequence decoder, emits one request per byte with output
module u8u16_front (
  input  logic            clk,
  input  logic            rst_n,
  u8u16_in_if.sink        in_ch,
  input  logic            q_full,
  output logic            q_push,
  output u8u16_pkg::desc_t q_desc
);
  import u8u16_pkg::*;

  typedef enum logic [2:0] {
    KIND_CONT,
    KIND_ASCII,
    KIND_LEAD2,
    KIND_LEAD3,
    KIND_LEAD4,
    KIND_BAD
  } kind_t;

  function automatic kind_t classify(input logic [7:0] b);
    kind_t k;
    priority if (b[7] == 1'b0)        k = KIND_ASCII;
    else if (b[7:6] == 2'b10)         k = KIND_CONT;
    else if (b[7:5] == 3'b110)        k = KIND_LEAD2;
    else if (b[7:4] == 4'b1110)       k = KIND_LEAD3;
    else if (b[7:3] == 5'b11110)      k = KIND_LEAD4;
    else                              k = KIND_BAD;
    return k;
  endfunction

  logic [7:0]      lead_r, lead_nxt;
  logic [1:0][5:0] pay_r, pay_nxt;
  logic [1:0]      held_r, held_nxt;
  logic [1:0]      need_r, need_nxt;

  kind_t       kind;
  logic        fresh;
  logic [2:0]  held_inc;
  logic [5:0]  low;
  logic [20:0] cp;
  desc_t       desc;
  logic        accept;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // decode one byte against the pending sequence
  always_comb begin
    kind     = classify(in_ch.in_byte);
    low      = in_ch.in_byte[5:0];
    held_inc = {1'b0, held_r} + 3'd1;
    lead_nxt = lead_r;
    pay_nxt  = pay_r;
    held_nxt = held_r;
    need_nxt = need_r;
    fresh    = 1'b1;
    cp       = '0;
    desc          = '0;
    desc.tail     = TAIL_NONE;
    desc.end_flag = in_ch.end_of_input;

    if (need_r != 2'd0) begin
      if (kind == KIND_CONT) begin
        fresh = 1'b0;
        if (held_inc >= {1'b0, need_r}) begin
          // sequence complete
          unique case (need_r)
            2'd1:    cp = {10'd0, lead_r[4:0], low};
            2'd2:    cp = {5'd0, lead_r[3:0], pay_r[0], low};
            default: cp = {lead_r[2:0], pay_r[0], pay_r[1], low};
          endcase
          desc.cp   = cp;
          desc.tail = (cp[20:16] != 5'd0) ? TAIL_PAIR : TAIL_UNIT;
          lead_nxt  = '0;
          pay_nxt   = '0;
          held_nxt  = '0;
          need_nxt  = '0;
        end else begin
          pay_nxt[held_r[0]] = low;
          held_nxt           = held_inc[1:0];
          // string ends inside the sequence
          if (in_ch.end_of_input) begin
            desc.n_qmark = held_inc[1:0] + 2'd1;
            lead_nxt     = '0;
            pay_nxt      = '0;
            held_nxt     = '0;
            need_nxt     = '0;
          end
        end
      end else begin
        // non-continuation cuts the sequence short
        desc.n_qmark = held_r + 2'd1;
        lead_nxt     = '0;
        pay_nxt      = '0;
        held_nxt     = '0;
        need_nxt     = '0;
      end
    end

    // new byte handled on its own
    if (fresh) begin
      unique case (kind)
        KIND_ASCII: begin
          desc.tail = TAIL_UNIT;
          desc.cp   = {13'd0, in_ch.in_byte};
        end
        KIND_LEAD2, KIND_LEAD3, KIND_LEAD4: begin
          if (in_ch.end_of_input) begin
            desc.tail = TAIL_UNIT;
            desc.cp   = {5'd0, QMARK};
          end else begin
            lead_nxt = in_ch.in_byte;
            held_nxt = '0;
            unique case (kind)
              KIND_LEAD2: need_nxt = 2'd1;
              KIND_LEAD3: need_nxt = 2'd2;
              default:    need_nxt = 2'd3;
            endcase
          end
        end
        default: begin
          desc.tail = TAIL_UNIT;
          desc.cp   = {5'd0, QMARK};
        end
      endcase
    end
  end

  assign q_desc = desc;
  assign q_push = accept && ((desc.n_qmark != 2'd0) || (desc.tail != TAIL_NONE));

  // pending sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r <= '0;
      pay_r  <= '0;
      held_r <= '0;
      need_r <= '0;
    end else if (accept) begin
      lead_r <= lead_nxt;
      pay_r  <= pay_nxt;
      held_r <= held_nxt;
      need_r <= need_nxt;
    end
  end

endmodule

### rtl/core/u8u16_fifo.sv
// request queue between decoder and unit sequencer
module u8u16_fifo #(
  parameter int unsigned DEPTH = u8u16_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  u8u16_pkg::desc_t wr_desc,
  input  logic             pop,
  output u8u16_pkg::desc_t rd_desc,
  output logic             full,
  output logic             empty
);
  import u8u16_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  desc_t         mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign rd_desc = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
    if (pop)  rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + AW'(1);
    if (push && !pop)      cnt_nxt = cnt_r + CW'(1);
    else if (pop && !push) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_desc;
  end

endmodule

### rtl/core/u8u16_back.sv
// unit sequencer: expands each request into code units through an output register
module u8u16_back (
  input  logic             clk,
  input  logic             rst_n,
  input  u8u16_pkg::desc_t q_desc,
  input  logic             q_empty,
  output logic             q_pop,
  u8u16_out_if.source      out_ch
);
  import u8u16_pkg::*;

  logic [1:0]  step_r, step_nxt;
  logic        out_valid_r;
  logic [15:0] unit_r;
  logic        run_last_r;
  logic        string_last_r;

  logic [2:0]  total;
  logic        last;
  logic        load;
  logic [20:0] idx;
  logic [15:0] unit;

  // units in the head request and the one at this step
  always_comb begin
    unique case (q_desc.tail)
      TAIL_UNIT: total = {1'b0, q_desc.n_qmark} + 3'd1;
      TAIL_PAIR: total = {1'b0, q_desc.n_qmark} + 3'd2;
      default:   total = {1'b0, q_desc.n_qmark};
    endcase
    last = (({1'b0, step_r} + 3'd1) == total);
    idx  = q_desc.cp - PLANE1_BASE;
    if (step_r < q_desc.n_qmark)       unit = QMARK;
    else if (q_desc.tail == TAIL_UNIT) unit = q_desc.cp[15:0];
    else if (step_r == q_desc.n_qmark) unit = SURR_HI_BASE + {5'd0, idx[20:10]};
    else                               unit = SURR_LO_BASE + {6'd0, idx[9:0]};
  end

  assign load     = !out_valid_r || out_ch.ready;
  assign q_pop    = load && !q_empty && last;
  assign step_nxt = last ? 2'd0 : step_r + 2'd1;

  // output register and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else if (load) begin
      out_valid_r <= !q_empty;
      if (!q_empty) step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      unit_r        <= unit;
      run_last_r    <= last;
      string_last_r <= last && q_desc.end_flag;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.code_unit   = unit_r;
  assign out_ch.run_last    = run_last_r;
  assign out_ch.string_last = string_last_r;

endmodule

### rtl/core/utf8_to_utf16_transcoder_core.sv
// utf-8 to utf-16 transcoder top level
// a byte's request is written into the queue; the sequencer then loads its code units into the
// output register one at a time. throughput: one byte per cycle while the queue is not full;
//   a byte with results yields 1 to 4 code units, each held in the output register until taken
// a queue of QUEUE_DEPTH requests lets the decoder run ahead of the sequencer
// reset: synchronous active-low rst_n clears pending sequence, queue and output valid
module utf8_to_utf16_transcoder_core #(
  parameter int unsigned QUEUE_DEPTH = u8u16_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  u8u16_in_if.sink    in_ch,
  u8u16_out_if.source out_ch
);
  import u8u16_pkg::*;

  desc_t push_desc;
  desc_t head_desc;
  logic  q_push;
  logic  q_pop;
  logic  q_full;
  logic  q_empty;

  u8u16_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_desc (push_desc)
  );

  u8u16_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_desc (push_desc),
    .pop     (q_pop),
    .rd_desc (head_desc),
    .full    (q_full),
    .empty   (q_empty)
  );

  u8u16_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_desc  (head_desc),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

### rtl/core/u8u16_checker.sv
// port-level checks of the transcoder and their binding
module u8u16_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] code_unit,
  input logic        run_last,
  input logic        string_last
);

  // output register is empty right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // a stalled request stays offered
  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output valid dropped under stall");

  // a stalled request keeps its payload
  a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(code_unit) && $stable(run_last)
      && $stable(string_last))
    else $error("output payload changed under stall");

  // end of string only on the last unit of a byte
  a_string_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && string_last |-> run_last)
    else $error("string_last without run_last");

  // an offered code unit carries no unknown bits
  a_payload_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown({code_unit, run_last, string_last}))
    else $error("unknown payload on offered code unit");

endmodule

bind utf8_to_utf16_transcoder_core u8u16_checker u_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .code_unit   (out_ch.code_unit),
  .run_last    (out_ch.run_last),
  .string_last (out_ch.string_last)
);

### dv/utf8_to_utf16_transcoder_core_test.sv
// self-checking testbench of the utf-8 to utf-16 transcoder core
`timescale 1ns / 100ps

module utf8_to_utf16_transcoder_core_test;
  import u8u16_pkg::*;

  localparam int RANDOM_BYTES = 90;
  localparam int IDLE_LIMIT   = 1000;
  localparam int TAIL_CYCLES  = 20;
  localparam logic [15:0] NO_UNIT = 16'h0000;

  // utf-8 byte classes, from the top five bits
  typedef enum logic [2:0] {
    CLS_CONT,
    CLS_ASCII,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_BAD
  } byte_class_t;

  // one byte request; fixed marks a row whose single result is typed in
  typedef struct packed {
    logic [7:0]  b;
    logic        eoi;
    logic        fixed;
    logic [15:0] unit;
  } byte_req_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        run_last;
    logic        string_last;
  } unit_t;

  logic clk = 1'b0;
  logic rst_n;

  u8u16_in_if  in_ch ();
  u8u16_out_if out_ch ();

  utf8_to_utf16_transcoder_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // directed bytes: extremes, stray and invalid bytes, early and end-of-string flushes
  byte_req_t directed_rows [29] = '{
    '{8'h00, 1'b0, 1'b1, 16'h0000},
    '{8'h7F, 1'b0, 1'b1, 16'h007F},
    '{8'h80, 1'b0, 1'b1, QMARK},
    '{8'hF8, 1'b0, 1'b1, QMARK},
    '{8'hFF, 1'b0, 1'b1, QMARK},
    '{8'hC0, 1'b0, 1'b0, NO_UNIT},
    '{8'h80, 1'b0, 1'b0, NO_UNIT},
    '{8'hDF, 1'b0, 1'b0, NO_UNIT},
    '{8'hBF, 1'b0, 1'b0, NO_UNIT},
    '{8'hEF, 1'b0, 1'b0, NO_UNIT},
    '{8'hBF, 1'b0, 1'b0, NO_UNIT},
    '{8'hBF, 1'b0, 1'b0, NO_UNIT},
    '{8'hF7, 1'b0, 1'b0, NO_UNIT},
    '{8'hBF, 1'b0, 1'b0, NO_UNIT},
    '{8'hBF, 1'b0, 1'b0, NO_UNIT},
    '{8'hBF, 1'b0, 1'b0, NO_UNIT},
    '{8'hE2, 1'b0, 1'b0, NO_UNIT},
    '{8'h41, 1'b0, 1'b0, NO_UNIT},
    '{8'hF0, 1'b0, 1'b0, NO_UNIT},
    '{8'h90, 1'b0, 1'b0, NO_UNIT},
    '{8'h80, 1'b0, 1'b0, NO_UNIT},
    '{8'h41, 1'b0, 1'b0, NO_UNIT},
    '{8'hC2, 1'b0, 1'b0, NO_UNIT},
    '{8'h80, 1'b1, 1'b0, NO_UNIT},
    '{8'hE1, 1'b1, 1'b1, QMARK},
    '{8'hF4, 1'b0, 1'b0, NO_UNIT},
    '{8'h8F, 1'b0, 1'b0, NO_UNIT},
    '{8'h80, 1'b1, 1'b0, NO_UNIT},
    '{8'h7F, 1'b1, 1'b1, 16'h007F}
  };

  byte_req_t byte_stream [$];
  unit_t     units_due [$];
  byte_req_t byte_in_flight;

  // decoder state mirror
  logic [7:0] lead_q;
  logic [5:0] payload_q [2];
  logic [1:0] held_q;
  logic [2:0] needed_q;

  // code units of the byte being decoded
  logic [15:0] step_units [4];
  int          step_n;

  // sender and receiver pacing
  int         burst_left = 0;
  int         gap_left = 0;
  logic [7:0] stall_mask = 8'hFF;
  logic [2:0] stall_phase = 3'd0;

  int idle_cycles = 0;
  int n_errors = 0;
  int n_bytes = 0;
  int n_units = 0;
  int n_surrogates = 0;
  int n_qmarks = 0;
  int n_strings = 0;

  function automatic byte_class_t classify(input logic [7:0] b);
    if (!b[7]) return CLS_ASCII;
    if (!b[6]) return CLS_CONT;
    if (!b[5]) return CLS_LEAD2;
    if (!b[4]) return CLS_LEAD3;
    if (!b[3]) return CLS_LEAD4;
    return CLS_BAD;
  endfunction

  task automatic emit_unit(input logic [15:0] unit);
    step_units[step_n] = unit;
    step_n++;
  endtask

  task automatic clear_sequence();
    lead_q = '0;
    payload_q[0] = '0;
    payload_q[1] = '0;
    held_q = '0;
    needed_q = '0;
  endtask

  // pending lead and each held continuation turn into one question mark each
  task automatic flush_sequence();
    emit_unit(QMARK);
    for (int k = 0; k < held_q && k < 2; k++) emit_unit(QMARK);
    clear_sequence();
  endtask

  task automatic emit_code_point(input logic [20:0] cp);
    logic [20:0] idx;
    if (cp <= 21'h00FFFF) begin
      emit_unit(cp[15:0]);
    end else begin
      idx = cp - PLANE1_BASE;
      emit_unit(SURR_HI_BASE + {5'b0, idx[20:10]});
      emit_unit(SURR_LO_BASE + {6'b0, idx[9:0]});
    end
  endtask

  // code units caused by one byte, with the decoder state update
  task automatic decode_byte(input logic [7:0] b, input logic eoi);
    byte_class_t cls;
    logic [20:0] cp;
    logic        fresh;
    cls = classify(b);
    step_n = 0;
    fresh = 1'b1;
    if (needed_q != 0) begin
      if (cls == CLS_CONT) begin
        fresh = 1'b0;
        if (held_q + 1 >= needed_q) begin
          case (needed_q)
            3'd1: cp = {10'd0, lead_q[4:0], b[5:0]};
            3'd2: cp = {5'd0, lead_q[3:0], payload_q[0], b[5:0]};
            default: cp = {lead_q[2:0], payload_q[0], payload_q[1], b[5:0]};
          endcase
          clear_sequence();
          emit_code_point(cp);
        end else begin
          payload_q[held_q[0]] = b[5:0];
          held_q = held_q + 2'd1;
          if (eoi) flush_sequence();
        end
      end else begin
        flush_sequence();
      end
    end
    if (fresh) begin
      case (cls)
        CLS_ASCII: emit_unit({8'h00, b});
        CLS_LEAD2, CLS_LEAD3, CLS_LEAD4: begin
          if (eoi) begin
            emit_unit(QMARK);
          end else begin
            lead_q = b;
            held_q = '0;
            case (cls)
              CLS_LEAD2: needed_q = 3'd1;
              CLS_LEAD3: needed_q = 3'd2;
              default: needed_q = 3'd3;
            endcase
          end
        end
        default: emit_unit(QMARK);
      endcase
    end
  endtask

  // queue the code units expected from an accepted byte
  task automatic accept_byte(input byte_req_t req);
    decode_byte(req.b, req.eoi);
    if (req.fixed) begin
      units_due.push_back('{req.unit, 1'b1, req.eoi});
    end else begin
      for (int i = 0; i < step_n; i++)
        units_due.push_back('{step_units[i], i == step_n - 1, (i == step_n - 1) && req.eoi});
    end
  endtask

  // byte sender: bursts of random length with random gaps
  task automatic send_byte();
    if (in_ch.valid && in_ch.ready) begin
      accept_byte(byte_in_flight);
      n_bytes++;
    end
    if (!in_ch.valid || in_ch.ready) begin
      if (gap_left != 0 || byte_stream.size() == 0) begin
        if (gap_left != 0) gap_left--;
        in_ch.valid <= 1'b0;
      end else begin
        byte_in_flight = byte_stream.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.in_byte <= byte_in_flight.b;
        in_ch.end_of_input <= byte_in_flight.eoi;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  endtask

  // code unit receiver: checks each unit, stalls by a random eight-bit ready mask
  task automatic take_unit();
    unit_t want;
    if (out_ch.valid && out_ch.ready) begin
      n_units++;
      if (out_ch.code_unit[15:11] == 5'b11011) n_surrogates++;
      if (out_ch.code_unit == QMARK) n_qmarks++;
      if (out_ch.string_last) n_strings++;
      if (units_due.size() == 0) begin
        $error("unexpected code unit %h", out_ch.code_unit);
        n_errors++;
      end else begin
        want = units_due.pop_front();
        if (out_ch.code_unit !== want.code_unit) begin
          $error("code_unit: expected %h, got %h", want.code_unit, out_ch.code_unit);
          n_errors++;
        end
        if (out_ch.run_last !== want.run_last) begin
          $error("run_last: expected %b, got %b", want.run_last, out_ch.run_last);
          n_errors++;
        end
        if (out_ch.string_last !== want.string_last) begin
          $error("string_last: expected %b, got %b", want.string_last, out_ch.string_last);
          n_errors++;
        end
      end
    end
    if (stall_phase == 3'd0) begin
      if ($urandom_range(0, 2) == 0) stall_mask = 8'hFF;
      else stall_mask = 8'($urandom) | (8'h01 << $urandom_range(0, 7));
    end
    out_ch.ready <= stall_mask[stall_phase];
    stall_phase = stall_phase + 3'd1;
  endtask

  // both channels in one process so checks never race the predictor
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      out_ch.ready <= 1'b0;
    end else begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      send_byte();
      take_unit();
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic eoi);
    byte_stream.push_back('{b, eoi, 1'b0, NO_UNIT});
  endtask

  // one utf-8 sequence of n_total bytes, cut after n_sent bytes
  task automatic add_sequence(input int n_total, input int n_sent, input logic eoi);
    logic [31:0] r;
    logic [7:0]  lead;
    r = $urandom;
    case (n_total)
      1: lead = {1'b0, r[6:0]};
      2: lead = {3'b110, r[4:0]};
      3: lead = {4'b1110, r[3:0]};
      default: lead = {5'b11110, r[2:0]};
    endcase
    push_byte(lead, eoi && n_sent == 1);
    for (int k = 1; k < n_sent; k++) begin
      r = $urandom;
      push_byte({2'b10, r[5:0]}, eoi && k == n_sent - 1);
    end
  endtask

  initial begin
    int   pick;
    int   len;
    logic timed_out;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.in_byte = 8'h00;
    in_ch.end_of_input = 1'b0;
    out_ch.ready = 1'b0;
    clear_sequence();

    foreach (directed_rows[i]) byte_stream.push_back(directed_rows[i]);
    // mostly well-formed sequences, mixed with cut sequences and raw noise
    while (byte_stream.size() < $size(directed_rows) + RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        len = $urandom_range(1, 4);
        add_sequence(len, len, $urandom_range(0, 5) == 0);
      end else if (pick < 85) begin
        len = $urandom_range(2, 4);
        add_sequence(len, $urandom_range(1, len - 1), $urandom_range(0, 3) == 0);
      end else begin
        push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while ((byte_stream.size() != 0 || in_ch.valid || units_due.size() != 0) &&
           idle_cycles < IDLE_LIMIT)
      @(posedge clk);
    timed_out = (idle_cycles >= IDLE_LIMIT);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d bytes sent (%0d directed), %0d code units checked",
             n_bytes, $size(directed_rows), n_units);
    $display("%0d surrogate halves, %0d question marks, %0d string ends seen",
             n_surrogates, n_qmarks, n_strings);
    if (!timed_out && n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
